/* rtl/fers_pkg.sv */
package fers_pkg;

    localparam int unsigned ADDR_BITS = 24;

    localparam int unsigned ADDR_W = 24;
    localparam int unsigned SIZE_W = 25;
    localparam int unsigned SUM_W  = 26;

    localparam logic [SUM_W-1:0] ADDR_SPAN = SUM_W'(1) << ADDR_BITS;

    localparam logic [SIZE_W-1:0] FLASH_SIZE_RESET = SIZE_W'(16777216);

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_DONE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    localparam logic [2:0] ST_ISSUE   = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_ARGS    = 3'd2;
    localparam logic [2:0] ST_TIMEOUT = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [7:0] CMD_4K  = 8'h20;
    localparam logic [7:0] CMD_32K = 8'h52;
    localparam logic [7:0] CMD_64K = 8'hD8;

    localparam logic [SIZE_W-1:0] SZ_4K  = SIZE_W'(4 * 1024);
    localparam logic [SIZE_W-1:0] SZ_32K = SIZE_W'(32 * 1024);
    localparam logic [SIZE_W-1:0] SZ_64K = SIZE_W'(64 * 1024);

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        erase_opcode;
        logic [ADDR_W-1:0] erase_addr;
    } result_t;

endpackage

/* rtl/fers_out_buf.sv */
module fers_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  fers_pkg::result_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output fers_pkg::result_t pop_data
);
    import fers_pkg::*;

    logic    head_valid_reg;
    logic    head_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t head_reg;
    result_t head_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;
    logic    push;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = head_valid_reg;
    assign pop_data   = head_reg;
    assign pop        = head_valid_reg && pop_ready;
    assign push       = push_valid && push_ready;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // skid only fills behind an occupied head
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid beat without head beat");

    // a held head beat is not overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid_reg && !pop_ready) |=> (head_valid_reg && $stable(head_reg)))
        else $error("stalled head beat changed");

    // a beat pushed into a full head lands in the skid
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && head_valid_reg && !pop) |=> skid_valid_reg)
        else $error("pushed beat lost");

endmodule

/* rtl/flash_erase_range_splitter_core.sv */
// channel  | handshake             | beat
// ---------+-----------------------+----------------------------------------
// in       | in_valid / in_ready   | op, start_addr, range_size
// out      | out_valid / out_ready | status, erase_opcode, erase_addr
// cfg      | cfg_valid / cfg_ready | cfg_data (flash size in bytes)
//
// one input beat per cycle while in_ready is high; each beat yields one registered result beat
// the result leaves from a two-entry output buffer, so input stalls only when both
// entries are held by a stalled output
// cfg_ready is always high; the flash size register takes effect on the next beat
// rst_n clears the range state to idle and the flash size to 16 MiB
module flash_erase_range_splitter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   op,
    input  logic [fers_pkg::ADDR_W-1:0]  start_addr,
    input  logic [fers_pkg::SIZE_W-1:0]  range_size,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   status,
    output logic [7:0]                   erase_opcode,
    output logic [fers_pkg::ADDR_W-1:0]  erase_addr,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fers_pkg::SIZE_W-1:0]  cfg_data
);
    import fers_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] current_addr_reg;
    logic [ADDR_W-1:0] current_addr_next;
    logic [SIZE_W-1:0] remaining_bytes_reg;
    logic [SIZE_W-1:0] remaining_bytes_next;
    logic [SIZE_W-1:0] flash_size_reg;

    logic              in_accept;
    logic [SUM_W-1:0]  range_end;
    logic [SUM_W-1:0]  limit;
    logic              args_bad;
    logic [ADDR_W-1:0] issue_addr;
    logic [SIZE_W-1:0] issue_rem;
    logic [SIZE_W-1:0] blk_size;
    logic [SIZE_W-1:0] step_size;
    logic [7:0]        blk_cmd;
    result_t           res;
    result_t           out_beat;

    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign range_end = {2'b00, start_addr} + {1'b0, range_size};
    assign limit     = ({1'b0, flash_size_reg} > ADDR_SPAN) ? ADDR_SPAN
                                                            : {1'b0, flash_size_reg};
    assign args_bad  = (start_addr[11:0] != 12'd0) || (range_size[11:0] != 12'd0)
                    || (range_size == '0) || (range_end > limit);

    // block choice, shared by start and completion
    assign issue_addr = (op == OP_START) ? start_addr : current_addr_reg;
    assign issue_rem  = (op == OP_START) ? range_size : remaining_bytes_reg;

    always_comb
    begin
        if (issue_rem >= SZ_64K && issue_addr[15:0] == 16'd0)
        begin
            blk_size = SZ_64K;
            blk_cmd  = CMD_64K;
        end
        else if (issue_rem >= SZ_32K && issue_addr[14:0] == 15'd0)
        begin
            blk_size = SZ_32K;
            blk_cmd  = CMD_32K;
        end
        else
        begin
            blk_size = SZ_4K;
            blk_cmd  = CMD_4K;
        end
    end

    assign step_size = (blk_size > issue_rem) ? issue_rem : blk_size;

    always_comb
    begin
        busy_next            = busy_reg;
        current_addr_next    = current_addr_reg;
        remaining_bytes_next = remaining_bytes_reg;
        res.status           = ST_IGNORED;
        res.erase_opcode     = 8'd0;
        res.erase_addr       = '0;
        case (op)
            OP_START:
            begin
                if (!busy_reg)
                begin
                    if (args_bad)
                    begin
                        res.status = ST_ARGS;
                    end
                    else
                    begin
                        busy_next            = 1'b1;
                        res.status           = ST_ISSUE;
                        res.erase_opcode     = blk_cmd;
                        res.erase_addr       = issue_addr;
                        current_addr_next    = issue_addr + step_size[ADDR_W-1:0];
                        remaining_bytes_next = issue_rem - step_size;
                    end
                end
            end
            OP_DONE:
            begin
                if (busy_reg)
                begin
                    if (remaining_bytes_reg == '0)
                    begin
                        busy_next  = 1'b0;
                        res.status = ST_OK;
                    end
                    else
                    begin
                        res.status           = ST_ISSUE;
                        res.erase_opcode     = blk_cmd;
                        res.erase_addr       = issue_addr;
                        current_addr_next    = issue_addr + step_size[ADDR_W-1:0];
                        remaining_bytes_next = issue_rem - step_size;
                    end
                end
            end
            OP_TIMEOUT:
            begin
                if (busy_reg)
                begin
                    busy_next            = 1'b0;
                    remaining_bytes_next = '0;
                    res.status           = ST_TIMEOUT;
                end
            end
            default:
            begin
                res.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg            <= 1'b0;
            current_addr_reg    <= '0;
            remaining_bytes_reg <= '0;
            flash_size_reg      <= FLASH_SIZE_RESET;
        end
        else
        begin
            if (in_accept)
            begin
                busy_reg            <= busy_next;
                current_addr_reg    <= current_addr_next;
                remaining_bytes_reg <= remaining_bytes_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                flash_size_reg <= cfg_data;
            end
        end
    end

    fers_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (res),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (out_beat)
    );

    assign status       = out_beat.status;
    assign erase_opcode = out_beat.erase_opcode;
    assign erase_addr   = out_beat.erase_addr;

    // idle always leaves nothing pending
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (remaining_bytes_reg == '0))
        else $error("bytes left while idle");

    // erase beats carry a real command, other beats carry zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ISSUE) |->
            (erase_opcode == CMD_4K || erase_opcode == CMD_32K || erase_opcode == CMD_64K))
        else $error("erase beat with bad opcode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_ISSUE) |-> (erase_opcode == 8'd0 && erase_addr == '0))
        else $error("non-erase beat with payload");

    // an accepted start while idle with good arguments makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op == OP_START && !busy_reg && !args_bad) |=> busy_reg)
        else $error("range start not taken");

endmodule
